// ----- sv/hbs_pkg.sv -----
// ---------------------------------------------------------------------------
// hbs_pkg: shared constants and helpers for the hierarchical bitmap set
// Sizes, command codes and the 64-bit priority encoders.
// ---------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

    localparam int WORD_BITS    = 64;
    localparam int UNIVERSE_MAX = 4096;
    localparam int LEAF_COUNT   = UNIVERSE_MAX / WORD_BITS;
    localparam int BIT_IDX_W    = $clog2(WORD_BITS);
    localparam int LEAF_IDX_W   = $clog2(LEAF_COUNT);
    localparam int ELEM_W       = LEAF_IDX_W + BIT_IDX_W;
    localparam int SIZE_W       = 13;
    localparam int POS_W        = 14;
    localparam int CMD_W        = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TEST   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PREV   = 3'd4;

    typedef logic [WORD_BITS-1:0] word_t;

    // lowest set bit, 0 when the word is empty
    function automatic logic [BIT_IDX_W-1:0] low_bit(input word_t x);
        logic [BIT_IDX_W-1:0] k;
        k = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (x[j])
                k = BIT_IDX_W'(j);
        end
        return k;
    endfunction

    // highest set bit, 0 when the word is empty
    function automatic logic [BIT_IDX_W-1:0] high_bit(input word_t x);
        logic [BIT_IDX_W-1:0] k;
        k = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (x[j])
                k = BIT_IDX_W'(j);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- sv/hierarchical_bitmap_set.sv -----
// ---------------------------------------------------------------------------
// hierarchical_bitmap_set: ordered integer set in a two-level bitmap tree
// 64 leaf words in a synchronous RAM plus one summary word in flops.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: s_tuser carries the command (insert, erase, test, next,
//   prev), s_tdata the signed element index. One word in gives exactly one
//   word out on the master stream: m_tuser = found, m_tdata = position.
//   cfg_wr_en/cfg_wr_data load universe_size; write only while idle.
// Sequencing:
//   A word is taken in ST_IDLE, the leaf RAM is read in ST_LOOK, and the
//   result is registered from ST_LEAF1 once the output register is free;
//   a new word is taken only back in ST_IDLE. A next or prev that misses in
//   its own leaf word, with a candidate word in the summary, adds ST_LEAF2
//   and one more RAM read of the leaf word picked from the summary word.
// Reset:
//   All leaf words read as zero through per-word valid flops, the summary
//   word is cleared and universe_size returns to 4096. No clearing pass.
// Stall:
//   The result sits in an output register; while it waits the next word
//   is still taken and looked up, and the sequencer holds (without writing
//   the RAM) only when a second result would overwrite an untaken one.
// ---------------------------------------------------------------------------
`default_nettype none

module hierarchical_bitmap_set
    import hbs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // config
    input  wire logic              cfg_wr_en,
    input  wire logic [SIZE_W-1:0] cfg_wr_data,   // universe_size
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,       // [13:0] query_index
    input  wire logic [CMD_W-1:0]  s_tuser,       // [2:0] command
    // output stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,       // [13:0] position, [15:14] zero
    output logic                   m_tuser        // [0] found
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOOK  = 4'b0010,
        ST_LEAF1 = 4'b0100,
        ST_LEAF2 = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // latched word
    logic [CMD_W-1:0]      cmd_reg;
    logic [POS_W-1:0]      idx_reg;
    // lookup context, captured in the RAM read cycle
    logic [ELEM_W-1:0]     elem_reg;
    logic                  act_reg;
    logic                  alt_ok_reg;
    logic [LEAF_IDX_W-1:0] alt_w_reg;

    logic [SIZE_W-1:0]     universe_size_reg;
    word_t                 summary_reg, summary_next;
    logic [LEAF_COUNT-1:0] leaf_vld_reg;

    // leaf RAM
    word_t                 leaf_mem [0:LEAF_COUNT-1];
    word_t                 rd_data_reg;
    logic                  rd_vld_reg;
    logic                  rd_en;
    logic [LEAF_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    word_t                 wr_data;

    // output register
    logic                  m_tvalid_reg;
    logic                  found_reg;
    logic [POS_W-1:0]      pos_reg;

    // lookup-cycle signals
    logic [SIZE_W-1:0]     n_eff;
    logic                  idx_neg;
    logic [SIZE_W-1:0]     idx_pos;
    logic [SIZE_W-1:0]     elem_clamp;
    logic                  act_look;
    logic [LEAF_IDX_W-1:0] look_w;
    word_t                 sum_above;
    word_t                 sum_below;
    logic                  alt_ok_look;
    logic [LEAF_IDX_W-1:0] alt_w_look;

    // leaf-cycle signals
    word_t                 leaf;
    logic [BIT_IDX_W-1:0]  bit_b;
    logic [LEAF_IDX_W-1:0] word_w;
    word_t                 bit_mask;
    word_t                 d_next;
    word_t                 d_prev;
    logic [ELEM_W-1:0]     r_elem;
    logic                  res_found;
    logic [POS_W-1:0]      res_pos;
    logic                  res_load;
    logic                  out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = {2'b00, pos_reg};

    // effective universe and index clamping
    always_comb
    begin
        n_eff   = (universe_size_reg > SIZE_W'(UNIVERSE_MAX)) ? SIZE_W'(UNIVERSE_MAX)
                                                              : universe_size_reg;
        idx_neg = idx_reg[POS_W-1];
        idx_pos = idx_reg[SIZE_W-1:0];
        elem_clamp = idx_pos;
        act_look   = 1'b0;
        case (cmd_reg)
            CMD_INSERT, CMD_ERASE, CMD_TEST:
            begin
                act_look = !idx_neg && (idx_pos < n_eff);
            end
            CMD_NEXT:
            begin
                elem_clamp = idx_neg ? '0 : idx_pos;
                act_look   = (elem_clamp < n_eff);
            end
            CMD_PREV:
            begin
                elem_clamp = (idx_pos >= n_eff) ? (n_eff - SIZE_W'(1)) : idx_pos;
                act_look   = !idx_neg && (n_eff != '0);
            end
            default:
            begin
                act_look = 1'b0;
            end
        endcase
        look_w = elem_clamp[ELEM_W-1:BIT_IDX_W];
    end

    // summary words strictly above / below the looked-up leaf word
    always_comb
    begin
        for (int k = 0; k < WORD_BITS; k++)
        begin
            sum_above[k] = summary_reg[k] && (k > int'(look_w));
            sum_below[k] = summary_reg[k] && (k < int'(look_w));
        end
        if (cmd_reg == CMD_NEXT)
        begin
            alt_ok_look = (sum_above != '0);
            alt_w_look  = LEAF_IDX_W'(low_bit(sum_above));
        end
        else
        begin
            alt_ok_look = (sum_below != '0);
            alt_w_look  = LEAF_IDX_W'(high_bit(sum_below));
        end
    end

    // leaf word evaluation and sequencing
    always_comb
    begin
        leaf     = rd_vld_reg ? rd_data_reg : '0;
        bit_b    = elem_reg[BIT_IDX_W-1:0];
        word_w   = elem_reg[ELEM_W-1:BIT_IDX_W];
        bit_mask = word_t'(1) << bit_b;
        d_next   = leaf & ({WORD_BITS{1'b1}} << bit_b);
        d_prev   = leaf & ({WORD_BITS{1'b1}} >> (BIT_IDX_W'(WORD_BITS - 1) - bit_b));
        r_elem   = '0;

        state_next   = state_reg;
        summary_next = summary_reg;
        res_found    = 1'b0;
        res_pos      = idx_reg;
        res_load     = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = look_w;
        wr_en        = 1'b0;
        wr_data      = leaf;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                rd_en      = 1'b1;
                state_next = ST_LEAF1;
            end
            ST_LEAF1:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        res_found = act_reg && leaf[bit_b];
                        wr_data   = leaf | bit_mask;
                        if (act_reg)
                            summary_next[word_w] = 1'b1;
                        wr_en     = act_reg;
                    end
                    CMD_ERASE:
                    begin
                        res_found = act_reg && leaf[bit_b];
                        wr_data   = leaf & ~bit_mask;
                        if (act_reg && (wr_data == '0))
                            summary_next[word_w] = 1'b0;
                        wr_en     = act_reg;
                    end
                    CMD_TEST:
                    begin
                        res_found = act_reg && leaf[bit_b];
                    end
                    CMD_NEXT:
                    begin
                        res_pos = POS_W'(n_eff);
                        r_elem  = {word_w, low_bit(d_next)};
                        if (act_reg && (d_next != '0))
                        begin
                            if ({1'b0, r_elem} < n_eff)
                            begin
                                res_found = 1'b1;
                                res_pos   = POS_W'(r_elem);
                            end
                        end
                    end
                    CMD_PREV:
                    begin
                        res_pos = '1;
                        r_elem  = {word_w, high_bit(d_prev)};
                        if (act_reg && (d_prev != '0))
                        begin
                            res_found = 1'b1;
                            res_pos   = POS_W'(r_elem);
                        end
                    end
                    default:
                    begin
                        res_found = 1'b0;
                    end
                endcase

                // a miss in the own leaf word jumps to the summary pick
                if (act_reg && alt_ok_reg &&
                    (((cmd_reg == CMD_NEXT) && (d_next == '0)) ||
                     ((cmd_reg == CMD_PREV) && (d_prev == '0))))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = alt_w_reg;
                    state_next = ST_LEAF2;
                end
                else if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
                if (!res_load)
                begin
                    wr_en        = 1'b0;
                    summary_next = summary_reg;
                end
            end
            ST_LEAF2:
            begin
                if (cmd_reg == CMD_NEXT)
                begin
                    res_pos = POS_W'(n_eff);
                    r_elem  = {alt_w_reg, low_bit(leaf)};
                    if ((leaf != '0) && ({1'b0, r_elem} < n_eff))
                    begin
                        res_found = 1'b1;
                        res_pos   = POS_W'(r_elem);
                    end
                end
                else
                begin
                    res_pos = '1;
                    r_elem  = {alt_w_reg, high_bit(leaf)};
                    if (leaf != '0)
                    begin
                        res_found = 1'b1;
                        res_pos   = POS_W'(r_elem);
                    end
                end
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // leaf RAM: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            leaf_mem[word_w] <= wr_data;
        if (rd_en)
            rd_data_reg <= leaf_mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            universe_size_reg <= SIZE_W'(UNIVERSE_MAX);
            summary_reg       <= '0;
            leaf_vld_reg      <= '0;
            rd_vld_reg        <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            summary_reg <= summary_next;
            if (cfg_wr_en)
                universe_size_reg <= cfg_wr_data;
            if (wr_en)
                leaf_vld_reg[word_w] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= leaf_vld_reg[rd_addr];
            if (res_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser;
            idx_reg <= s_tdata[POS_W-1:0];
        end
        if (state_reg == ST_LOOK)
        begin
            elem_reg   <= elem_clamp[ELEM_W-1:0];
            act_reg    <= act_look;
            alt_ok_reg <= alt_ok_look;
            alt_w_reg  <= alt_w_look;
        end
        if (res_load)
        begin
            found_reg <= res_found;
            pos_reg   <= res_pos;
        end
    end

endmodule

`default_nettype wire

// ----- sim/hierarchical_bitmap_set_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hierarchical_bitmap_set_test: self-checking bench for the bitmap-tree set
// Sends insert/erase/test/next/prev words and predicts every answer from a
// private copy of the leaf and summary words. The run goes through several
// universe sizes, with bursty input and a stalling output side.
// ---------------------------------------------------------------------------
module hierarchical_bitmap_set_test;
    import hbs_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_WORDS   = 110;     // random words per universe size
    localparam int DRAIN_CYCLES  = 8;       // idle cycles before a register write and at the end

    // command codes the block does not define; they must echo and do nothing
    localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] query_index;
    } set_cmd_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } set_answer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;       // [13:0] query_index, [15:14] zero
    logic [CMD_W-1:0]  s_tuser = '0;       // [2:0] command
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;            // [13:0] position, [15:14] zero
    logic              m_tuser;            // [0] found

    // commands waiting to be sent, answers waiting to come back
    set_cmd_t    cmd_queue[$];
    set_answer_t answer_queue[$];

    // shadow of the set: one bit per member plus the non-empty-word summary
    word_t             shadow_leaf[LEAF_COUNT];
    word_t             shadow_summary = '0;
    logic [SIZE_W-1:0] shadow_universe = SIZE_W'(UNIVERSE_MAX);

    int error_count = 0;
    int cycle_count = 0;
    int hot_word[3];                       // leaf words the random part crowds into
    bit word_taken = 1'b0;                 // set at the edge that took s_tdata
    int burst_left = 0;
    int gap_left = 0;

    hierarchical_bitmap_set u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int k = 0; k < LEAF_COUNT; k++)
            shadow_leaf[k] = '0;
    end

    // ------------------------------------------------------------------
    // Shadow set
    // ------------------------------------------------------------------
    function automatic int lowest_set(input word_t x);
        for (int k = 0; k < WORD_BITS; k++)
        begin
            if (x[k])
                return k;
        end
        return 0;
    endfunction

    function automatic int highest_set(input word_t x);
        for (int k = WORD_BITS - 1; k >= 0; k--)
        begin
            if (x[k])
                return k;
        end
        return 0;
    endfunction

    // Applies one command to the shadow set and returns the answer it owes.
    function automatic set_answer_t apply_set_command(input set_cmd_t op);
        set_answer_t ans;
        int    n;
        int    idx;
        int    i;
        int    w;
        int    b;
        int    w2;
        int    r;
        word_t d;
        word_t s;
        word_t m;
        // sizes above the maximum behave as the maximum; 0 is an empty set
        n   = (shadow_universe > UNIVERSE_MAX) ? UNIVERSE_MAX : int'(shadow_universe);
        idx = int'($signed(op.query_index));
        ans.found = 1'b0;
        r = idx;
        case (op.command)
            CMD_INSERT, CMD_ERASE, CMD_TEST:
            begin
                // out-of-universe index: answer 0, leave the set alone
                if (idx >= 0 && idx < n)
                begin
                    w = idx / WORD_BITS;
                    b = idx % WORD_BITS;
                    ans.found = shadow_leaf[w][b];
                    if (op.command == CMD_INSERT)
                    begin
                        shadow_leaf[w][b] = 1'b1;
                        shadow_summary[w] = 1'b1;
                    end
                    else if (op.command == CMD_ERASE)
                    begin
                        shadow_leaf[w][b] = 1'b0;
                        if (shadow_leaf[w] == '0)
                            shadow_summary[w] = 1'b0;
                    end
                end
            end
            CMD_NEXT:
            begin
                // negative index starts at 0; a hit at or above n is no hit
                i = (idx < 0) ? 0 : idx;
                r = -1;
                if (i < n)
                begin
                    w = i / WORD_BITS;
                    b = i % WORD_BITS;
                    d = shadow_leaf[w] >> b;
                    if (d != '0)
                        r = w * WORD_BITS + b + lowest_set(d);
                    else if (w + 1 < WORD_BITS)
                    begin
                        s = shadow_summary >> (w + 1);
                        if (s != '0)
                        begin
                            w2 = w + 1 + lowest_set(s);
                            if (w2 < LEAF_COUNT && shadow_leaf[w2] != '0)
                                r = w2 * WORD_BITS + lowest_set(shadow_leaf[w2]);
                        end
                    end
                end
                if (r >= 0 && r < n)
                    ans.found = 1'b1;
                else
                    r = n;
            end
            CMD_PREV:
            begin
                // negative index finds nothing; index past the end drops to n-1
                r = -1;
                if (idx >= 0)
                begin
                    i = (idx >= n) ? n - 1 : idx;
                    if (i >= 0)
                    begin
                        w = i / WORD_BITS;
                        b = i % WORD_BITS;
                        m = (b == WORD_BITS - 1) ? '1 : ((word_t'(1) << (b + 1)) - 1);
                        d = shadow_leaf[w] & m;
                        if (d != '0)
                            r = w * WORD_BITS + highest_set(d);
                        else
                        begin
                            s = shadow_summary & ((word_t'(1) << w) - 1);
                            if (s != '0)
                            begin
                                w2 = highest_set(s);
                                if (shadow_leaf[w2] != '0)
                                    r = w2 * WORD_BITS + highest_set(shadow_leaf[w2]);
                            end
                        end
                    end
                end
                ans.found = (r >= 0);
            end
            default: ;   // unused codes echo the index
        endcase
        ans.position = POS_W'(r);
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cmd(input logic [CMD_W-1:0] c, input int idx);
        set_cmd_t op;
        op.command     = c;
        op.query_index = POS_W'(idx);
        cmd_queue = {cmd_queue, op};
    endtask

    task automatic wait_drained;
        while (cmd_queue.size() != 0 || answer_queue.size() != 0 || s_tvalid)
            @(posedge clk);
    endtask

    // Register write only with the pipe empty; the shadow copy follows at once
    // since no word can be taken before the write lands.
    task automatic set_universe(input logic [SIZE_W-1:0] v);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en       <= 1'b1;
        cfg_wr_data     <= v;
        shadow_universe  = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly indices packed into a few leaf words with only a handful of bits
    // each, so erases empty words and next/prev have to jump via the summary.
    function automatic int random_index(input int n);
        int roll;
        int words;
        int w;
        roll  = $urandom_range(0, 99);
        words = (n + WORD_BITS - 1) / WORD_BITS;
        if (n > 0 && roll < 70)
        begin
            w = hot_word[$urandom_range(0, 2)] % words;
            if ($urandom_range(0, 3) == 0)
                return w * WORD_BITS + $urandom_range(0, WORD_BITS - 1);
            return w * WORD_BITS + $urandom_range(0, 7);
        end
        if (roll < 85)
        begin
            case ($urandom_range(0, 3))
                0:       return n - 1;
                1:       return n;
                2:       return 0;
                default: return -1;
            endcase
        end
        return $urandom_range(0, (1 << POS_W) - 1);   // anything in 14 bits
    endfunction

    function automatic logic [CMD_W-1:0] random_command;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return CMD_INSERT;
        if (roll < 48)
            return CMD_ERASE;
        if (roll < 58)
            return CMD_TEST;
        if (roll < 77)
            return CMD_NEXT;
        if (roll < 96)
            return CMD_PREV;
        return CMD_W'($urandom_range(CMD_UNUSED_5, CMD_UNUSED_7));
    endfunction

    task automatic push_random(input int count);
        int n;
        n = (shadow_universe > UNIVERSE_MAX) ? UNIVERSE_MAX : int'(shadow_universe);
        for (int k = 0; k < 3; k++)
            hot_word[k] = $urandom_range(0, LEAF_COUNT - 1);
        for (int k = 0; k < count; k++)
            push_cmd(random_command(), random_index(n));
    endtask

    // ------------------------------------------------------------------
    // Sequence: directed words at the reset size, then random phases at a
    // range of sizes. The shrink to 100 keeps members set above the new end,
    // which next must not report. 8191 is past the maximum, 0 is empty.
    // ------------------------------------------------------------------
    initial
    begin
        logic [SIZE_W-1:0] size_plan[9];
        size_plan = '{SIZE_W'(8191), SIZE_W'(100), SIZE_W'(1), SIZE_W'(0),
                      SIZE_W'(64), SIZE_W'($urandom_range(2, 4095)),
                      SIZE_W'(65), SIZE_W'(4096), SIZE_W'($urandom_range(1, 8191))};

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // empty set
        push_cmd(CMD_TEST, 0);
        push_cmd(CMD_NEXT, -1);                // clamps to 0, none -> n
        push_cmd(CMD_PREV, UNIVERSE_MAX);      // clamps to n-1, none -> -1
        // first and last members, double insert, out-of-universe inserts and erase
        push_cmd(CMD_INSERT, 0);
        push_cmd(CMD_INSERT, 0);
        push_cmd(CMD_INSERT, UNIVERSE_MAX - 1);
        push_cmd(CMD_INSERT, -1);
        push_cmd(CMD_INSERT, UNIVERSE_MAX);
        push_cmd(CMD_INSERT, (1 << (POS_W - 1)) - 1);
        push_cmd(CMD_ERASE, -(1 << (POS_W - 1)));
        // next/prev that have to cross empty words through the summary
        push_cmd(CMD_INSERT, 700);
        push_cmd(CMD_NEXT, 1);
        push_cmd(CMD_NEXT, UNIVERSE_MAX);
        push_cmd(CMD_PREV, 699);
        push_cmd(CMD_PREV, (1 << (POS_W - 1)) - 1);
        push_cmd(CMD_PREV, -1);
        push_cmd(CMD_TEST, UNIVERSE_MAX - 1);
        // erase that empties a leaf word must clear its summary bit
        push_cmd(CMD_ERASE, 700);
        push_cmd(CMD_NEXT, 1);
        push_cmd(CMD_ERASE, UNIVERSE_MAX - 1);
        push_cmd(CMD_PREV, UNIVERSE_MAX - 2);
        push_cmd(CMD_TEST, 700);
        // undefined codes
        push_cmd(CMD_UNUSED_5, UNIVERSE_MAX - 1);
        push_cmd(CMD_UNUSED_6, -1);
        push_cmd(CMD_UNUSED_7, 5461);

        push_random(PHASE_WORDS);
        foreach (size_plan[p])
        begin
            set_universe(size_plan[p]);
            push_random(PHASE_WORDS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input side. The taken word is predicted at the edge that takes it;
    // the next word (or a gap) goes out on the falling edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        set_cmd_t op;
        if (rst_n && s_tvalid && s_tready)
        begin
            op.command     = s_tuser;
            op.query_index = s_tdata[POS_W-1:0];
            answer_queue = {answer_queue, apply_set_command(op)};
            void'(cmd_queue.pop_front());
            word_taken = 1'b1;
        end
    end

    // Bursts of 1..16 words with random idle gaps; every third stretch of the
    // run goes back to back.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (word_taken || !s_tvalid)
        begin
            word_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (cmd_queue.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= cmd_queue[0].command;
                s_tdata  <= {2'b00, cmd_queue[0].query_index};
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ((cycle_count / 600) % 3 == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output side. Ready cycles through four moods: always ready, mostly
    // ready, a fixed periodic stall, mostly stalled.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        case ((cycle_count / 300) % 4)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ((cycle_count % 9) >= 4);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        set_answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (answer_queue.size() == 0)
            begin
                $display("%0t: word with none pending: found %0b position %0d",
                         $time, m_tuser, $signed(m_tdata[POS_W-1:0]));
                error_count++;
            end
            else
            begin
                want = answer_queue.pop_front();
                if (m_tuser !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, m_tuser);
                    error_count++;
                end
                if (m_tdata[POS_W-1:0] !== want.position)
                begin
                    $display("%0t: position expected %0d actual %0d", $time,
                             $signed(want.position), $signed(m_tdata[POS_W-1:0]));
                    error_count++;
                end
                if (m_tdata[15:POS_W] !== '0)
                begin
                    $display("%0t: tdata pad expected 0 actual %b",
                             $time, m_tdata[15:POS_W]);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

// ----- files.f -----
sv/hbs_pkg.sv
sv/hierarchical_bitmap_set.sv
sim/hierarchical_bitmap_set_test.sv
